### hdl/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

  // configuration address width: two 32-bit registers at byte addresses 0 and 4
  localparam int unsigned PADDR_W = 3;

  // verdict status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MARKER = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_BAD_SUM    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  // result kinds
  localparam logic ITEM_DATA    = 1'b0;
  localparam logic ITEM_VERDICT = 1'b1;

  // register indexes
  localparam logic REG_MARKER   = 1'b0;
  localparam logic REG_MAX_DATA = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        item_type;
    logic [7:0]  data_byte;
    logic [7:0]  command_code;
    logic [15:0] data_count;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // up to two results caused by one byte, in delivery order
  typedef struct packed {
    logic      first_valid;
    out_item_t first;
    logic      second_valid;
    out_item_t second;
  } parse_res_t;

endpackage

`default_nettype wire

### hdl/scfp_parser.sv
`default_nettype none

module scfp_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire scfp_pkg::in_item_t item,
  input  wire logic [7:0]         marker_value,
  input  wire logic [15:0]        max_data_bytes,
  output scfp_pkg::parse_res_t    res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  held_command, held_command_next;
  logic        over_limit, over_limit_next;
  logic        length_known, length_known_next;

  logic        verdict;
  logic [2:0]  verdict_status;
  logic        pass_data;
  logic [7:0]  b;
  logic        eob;
  scfp_pkg::out_item_t data_item, verdict_item;

  // data count of a frame: length minus the command byte
  function automatic logic [15:0] body_data_count(input logic [15:0] len);
    body_data_count = (len != 16'd0) ? len - 16'd1 : 16'd0;
  endfunction

  assign b   = item.rx_byte;
  assign eob = item.end_of_buffer;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    held_command_next = held_command;
    over_limit_next   = over_limit;
    length_known_next = length_known;
    verdict           = 1'b0;
    verdict_status    = scfp_pkg::ST_OK;
    pass_data         = 1'b0;

    case (phase)
      PH_IDLE: begin
        frame_length_next = '0;
        bytes_seen_next   = '0;
        running_sum_next  = '0;
        held_command_next = '0;
        over_limit_next   = 1'b0;
        length_known_next = 1'b0;
        if (b != marker_value) begin
          verdict        = 1'b1;
          verdict_status = scfp_pkg::ST_BAD_MARKER;
        end else if (eob) begin
          verdict        = 1'b1;
          verdict_status = scfp_pkg::ST_TRUNCATED;
        end else begin
          phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        frame_length_next = {b, 8'h00};
        running_sum_next  = running_sum + b;
        if (eob) begin
          verdict        = 1'b1;
          verdict_status = scfp_pkg::ST_TRUNCATED;
        end else begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        frame_length_next = {frame_length[15:8], b};
        running_sum_next  = running_sum + b;
        length_known_next = 1'b1;
        over_limit_next   = body_data_count({frame_length[15:8], b}) > max_data_bytes;
        bytes_seen_next   = '0;
        if (eob) begin
          verdict        = 1'b1;
          verdict_status = scfp_pkg::ST_TRUNCATED;
        end else begin
          phase_next = ({frame_length[15:8], b} == 16'd0) ? PH_CHECK : PH_BODY;
        end
      end
      PH_BODY: begin
        running_sum_next = running_sum + b;
        if (bytes_seen == 16'd0) begin
          held_command_next = b;
        end else if (!over_limit) begin
          pass_data = 1'b1;
        end
        bytes_seen_next = bytes_seen + 16'd1;
        if (bytes_seen_next >= frame_length) begin
          phase_next = PH_CHECK;
        end
        if (eob) begin
          verdict        = 1'b1;
          verdict_status = scfp_pkg::ST_TRUNCATED;
        end
      end
      PH_CHECK: begin
        if (frame_length == 16'd0) begin
          held_command_next = b;
        end
        verdict = 1'b1;
        if (running_sum + b != 8'd0) begin
          verdict_status = scfp_pkg::ST_BAD_SUM;
        end else if (over_limit) begin
          verdict_status = scfp_pkg::ST_TOO_LONG;
        end else begin
          verdict_status = scfp_pkg::ST_OK;
        end
      end
      PH_DONE: begin
        if (eob) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (verdict) begin
      phase_next = eob ? PH_IDLE : PH_DONE;
    end
  end

  always_comb begin
    data_item              = '0;
    data_item.item_type    = scfp_pkg::ITEM_DATA;
    data_item.data_byte    = b;

    verdict_item              = '0;
    verdict_item.item_type    = scfp_pkg::ITEM_VERDICT;
    verdict_item.command_code = held_command_next;
    verdict_item.data_count   = length_known_next ? body_data_count(frame_length_next) : 16'd0;
    verdict_item.status       = verdict_status;
    verdict_item.last         = 1'b1;

    if (pass_data) begin
      res.first_valid  = 1'b1;
      res.first        = data_item;
      res.second_valid = verdict;
      res.second       = verdict_item;
    end else begin
      res.first_valid  = verdict;
      res.first        = verdict_item;
      res.second_valid = 1'b0;
      res.second       = verdict_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
      held_command <= '0;
      over_limit   <= 1'b0;
      length_known <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
      held_command <= held_command_next;
      over_limit   <= over_limit_next;
      length_known <= length_known_next;
    end
  end

endmodule

`default_nettype wire

### hdl/sum_checked_frame_parser_top.sv
// sum-checked frame parser
// input channel (in_valid/in_ready/in_item): one received byte per transfer with
// its end-of-buffer flag; the stream starts at a candidate frame start
// output channel (out_valid/out_ready/out_item): passed-on data bytes and one
// verdict per frame attempt (status, command, data count, last set)
// configuration: apb-style port, marker_value at 0x0, max_data_bytes at 0x4,
// to be written by the user only while the block is idle (not enforced by
// the block); pready is tied high; a byte is captured in the input register
// at its transfer edge, and its first result then goes to the result register
// throughput: one byte per cycle while results are taken; a byte that yields
// both a data item and a truncated verdict makes the next byte wait in the
// input register while the verdict waits in the pending register
// reset: parser returns to idle awaiting a marker, registers take marker 0 and
// max_data_bytes 0xffff, both channels empty
// receiver stall: the result register holds, one more byte is taken into the
// input register, then in_ready drops until the result is taken
`default_nettype none

module sum_checked_frame_parser_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire scfp_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output scfp_pkg::out_item_t                out_item,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scfp_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // configuration registers
  logic [7:0]  marker_value;
  logic [15:0] max_data_bytes;
  logic        cfg_write;
  logic        cfg_index;

  // input register
  logic                in_full;
  scfp_pkg::in_item_t  in_reg;

  // pending second result of a byte
  logic                pend_valid;
  scfp_pkg::out_item_t pend_item;

  logic                 load_out;
  logic                 fire;
  scfp_pkg::parse_res_t res;

  assign pready    = 1'b1;
  assign cfg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_value   <= 8'h00;
      max_data_bytes <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        scfp_pkg::REG_MARKER:   marker_value   <= pwdata[7:0];
        scfp_pkg::REG_MAX_DATA: max_data_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      scfp_pkg::REG_MARKER:   prdata = {24'h000000, marker_value};
      scfp_pkg::REG_MAX_DATA: prdata = {16'h0000, max_data_bytes};
      default:                prdata = '0;
    endcase
  end

  // result register may load when empty or being taken this cycle;
  // a pending verdict goes out before the next byte is worked on
  assign load_out = !out_valid || out_ready;
  assign fire     = in_full && !pend_valid && load_out;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_item;
    end
  end

  scfp_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (fire),
    .item           (in_reg),
    .marker_value   (marker_value),
    .max_data_bytes (max_data_bytes),
    .res            (res)
  );

  // output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load_out) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (fire) begin
        out_valid  <= res.first_valid;
        pend_valid <= res.second_valid;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (pend_valid) begin
        out_item <= pend_item;
      end else if (fire) begin
        out_item  <= res.first;
        pend_item <= res.second;
      end
    end
  end

endmodule

`default_nettype wire

### bench/tb_sum_checked_frame_parser_top.sv
`timescale 1ns / 100ps

module tb_sum_checked_frame_parser_top;

  localparam int unsigned CLK_PERIOD        = 2;
  localparam int unsigned RESET_CYCLES      = 8;
  localparam int unsigned SETTLE_CYCLES     = 8;     // covers the path through the input and result registers
  localparam int unsigned WATCHDOG_LIMIT    = 2000;  // cycles with no transfer on either side
  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned PHASE_COUNT       = 6;
  localparam int unsigned BYTES_PER_PHASE   = 280;
  localparam int unsigned DIRECTED_ROWS     = 24;
  localparam int unsigned MAX_REPORTS       = 10;

  // where the parser stands in the current frame attempt
  localparam logic [2:0] AWAIT_MARKER = 3'd0;
  localparam logic [2:0] LEN_HIGH     = 3'd1;
  localparam logic [2:0] LEN_LOW      = 3'd2;
  localparam logic [2:0] IN_BODY      = 3'd3;
  localparam logic [2:0] AT_CHECK     = 3'd4;
  localparam logic [2:0] SKIP_TO_END  = 3'd5;

  // one row of the directed table: the byte, and optionally its result typed in
  typedef struct {
    scfp_pkg::in_item_t  stim;
    bit                  pinned;
    scfp_pkg::out_item_t want;
  } directed_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  scfp_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  scfp_pkg::out_item_t           out_item;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [scfp_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  sum_checked_frame_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the register file, kept in step with every write
  logic [7:0]   cfg_marker = 8'h00;
  logic [15:0]  cfg_max = 16'hFFFF;

  // shadow of the parser state
  logic [2:0]   parse_phase = AWAIT_MARKER;
  logic [15:0]  len_shadow = '0;
  logic [15:0]  body_count = '0;
  logic [7:0]   sum_acc = '0;
  logic [7:0]   cmd_hold = '0;
  bit           too_big = 1'b0;
  bit           len_ready = 1'b0;

  scfp_pkg::out_item_t byte_results [$];           // results caused by the latest byte
  scfp_pkg::out_item_t pending_parse_results [$];  // results still owed by the block
  scfp_pkg::in_item_t  rx_stream [$];              // bytes built but not yet offered

  int unsigned  tx_idle_pct = 12;
  int unsigned  rx_idle_pct = 74;
  bit           long_stall_request = 1'b0;
  int unsigned  parsed_bytes = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  stalled_cycles = 0;

  directed_row_t directed_rows [DIRECTED_ROWS];

  function automatic scfp_pkg::out_item_t verdict_item(input logic [2:0] st,
                                                       input logic [7:0] cmd,
                                                       input logic [15:0] cnt);
    scfp_pkg::out_item_t r;
    r = '0;
    r.item_type    = scfp_pkg::ITEM_VERDICT;
    r.command_code = cmd;
    r.data_count   = cnt;
    r.status       = st;
    r.last         = 1'b1;
    return r;
  endfunction

  // advance the shadow parser by one byte and collect what it should emit
  function automatic void parse_byte(input scfp_pkg::in_item_t stim);
    logic [7:0]  b;
    logic [7:0]  total;
    logic [15:0] cnt_val;
    logic [2:0]  st;
    bit          eob;
    bit          give_verdict;
    scfp_pkg::out_item_t r;
    b = stim.rx_byte;
    eob = stim.end_of_buffer;
    give_verdict = 1'b0;
    st = scfp_pkg::ST_OK;
    byte_results.delete();
    case (parse_phase)
      AWAIT_MARKER: begin
        len_shadow = '0;
        body_count = '0;
        sum_acc    = '0;
        cmd_hold   = '0;
        too_big    = 1'b0;
        len_ready  = 1'b0;
        if (b != cfg_marker) begin
          give_verdict = 1'b1;
          st = scfp_pkg::ST_BAD_MARKER;
        end else if (eob) begin
          give_verdict = 1'b1;
          st = scfp_pkg::ST_TRUNCATED;
        end else begin
          parse_phase = LEN_HIGH;
        end
      end
      LEN_HIGH: begin
        len_shadow = {b, 8'h00};
        sum_acc = sum_acc + b;
        if (eob) begin
          give_verdict = 1'b1;
          st = scfp_pkg::ST_TRUNCATED;
        end else begin
          parse_phase = LEN_LOW;
        end
      end
      LEN_LOW: begin
        len_shadow[7:0] = b;
        sum_acc = sum_acc + b;
        len_ready = 1'b1;
        cnt_val = (len_shadow != 16'd0) ? len_shadow - 16'd1 : 16'd0;
        // size limit is sampled here, not at the marker
        too_big = (cnt_val > cfg_max);
        body_count = '0;
        if (eob) begin
          give_verdict = 1'b1;
          st = scfp_pkg::ST_TRUNCATED;
        end else begin
          parse_phase = (len_shadow == 16'd0) ? AT_CHECK : IN_BODY;
        end
      end
      IN_BODY: begin
        sum_acc = sum_acc + b;
        if (body_count == 16'd0) begin
          cmd_hold = b;
        end else if (!too_big) begin
          r = '0;
          r.item_type = scfp_pkg::ITEM_DATA;
          r.data_byte = b;
          byte_results.push_back(r);
        end
        body_count = body_count + 16'd1;
        if (body_count >= len_shadow) parse_phase = AT_CHECK;
        // a data byte with the end flag gives its data item, then the verdict
        if (eob) begin
          give_verdict = 1'b1;
          st = scfp_pkg::ST_TRUNCATED;
        end
      end
      AT_CHECK: begin
        // with no body the check byte stands in for the command
        if (len_shadow == 16'd0) cmd_hold = b;
        total = sum_acc + b;
        give_verdict = 1'b1;
        // a bad sum wins over an oversize frame
        if (total != 8'h00) st = scfp_pkg::ST_BAD_SUM;
        else if (too_big) st = scfp_pkg::ST_TOO_LONG;
        else st = scfp_pkg::ST_OK;
      end
      default: begin
        if (eob) parse_phase = AWAIT_MARKER;
      end
    endcase
    if (give_verdict) begin
      cnt_val = (len_ready && len_shadow != 16'd0) ? len_shadow - 16'd1 : 16'd0;
      byte_results.push_back(verdict_item(st, cmd_hold, cnt_val));
      parse_phase = eob ? AWAIT_MARKER : SKIP_TO_END;
    end
  endfunction

  // offer one byte, hold it until the transfer, then record what it owes
  task automatic send_byte(input scfp_pkg::in_item_t stim, input bit pinned,
                           input scfp_pkg::out_item_t pinned_result);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= stim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // bytes swallowed after a verdict do not count toward the phase size
    if (parse_phase != SKIP_TO_END) parsed_bytes++;
    parse_byte(stim);
    if (pinned) pending_parse_results.push_back(pinned_result);
    else foreach (byte_results[i]) pending_parse_results.push_back(byte_results[i]);
  endtask

  // apb write: setup cycle, then access cycle; pready is tied high
  task automatic reg_write(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == scfp_pkg::REG_MARKER) cfg_marker = value[7:0];
    else cfg_max = value[15:0];
  endtask

  // build one buffer's worth of bytes; every buffer ends with the end flag set,
  // so the next one starts at a candidate frame start
  task automatic queue_sequence();
    scfp_pkg::in_item_t seq [$];
    logic [15:0]  len;
    logic [7:0]   sum;
    logic [7:0]   v;
    int unsigned  kind;
    int unsigned  pick;
    int unsigned  cut;
    kind = $urandom_range(99);
    if (kind < 75) begin
      // frame with random content, mostly well-formed
      pick = $urandom_range(99);
      if (pick < 8) len = 16'd0;
      else if (pick < 80) len = 16'($urandom_range(1, 12));
      else if (pick < 97) begin
        // straddle the size limit when it is small
        if (cfg_max < 16'd20) len = cfg_max + 16'($urandom_range(0, 3));
        else len = 16'($urandom_range(13, 40));
      end else len = 16'($urandom_range(200, 700));
      seq.push_back({cfg_marker, 1'b0});
      seq.push_back({len[15:8], 1'b0});
      seq.push_back({len[7:0], 1'b0});
      sum = len[15:8] + len[7:0];
      repeat (len) begin
        v = 8'($urandom);
        sum = sum + v;
        seq.push_back({v, 1'b0});
      end
      v = 8'h00 - sum;
      if ($urandom_range(99) < 15) v = v ^ 8'($urandom_range(1, 255));
      seq.push_back({v, 1'b0});
      pick = $urandom_range(99);
      if (pick < 12) begin
        // buffer runs out somewhere before the check byte
        cut = $urandom_range(0, seq.size() - 2);
        while (seq.size() > cut + 1) void'(seq.pop_back());
      end else if (pick < 25) begin
        // trailing bytes after the verdict are ignored
        repeat ($urandom_range(1, 4)) seq.push_back({8'($urandom), 1'b0});
      end
    end else if (kind < 88) begin
      // wrong start byte, then a little junk
      v = 8'($urandom);
      if (v == cfg_marker) v = ~v;
      seq.push_back({v, 1'b0});
      repeat ($urandom_range(0, 3)) seq.push_back({8'($urandom), 1'b0});
    end else begin
      // noise, often behind a good marker so the length bytes see random values
      if ($urandom_range(1) != 0) seq.push_back({cfg_marker, 1'b0});
      repeat ($urandom_range(1, 6))
        seq.push_back({8'($urandom), 1'($urandom_range(99) < 20)});
    end
    seq[seq.size() - 1].end_of_buffer = 1'b1;
    foreach (seq[i]) rx_stream.push_back(seq[i]);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_request) begin
        long_stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker: every result transfer against the oldest owed result
  always @(posedge clk) begin
    scfp_pkg::out_item_t want;
    bit                  bad;
    if (!rst && out_valid && out_ready) begin
      if (pending_parse_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result at %0t: ", $time,
                   "type %0d data %02h cmd %02h count %0d status %0d last %0d",
                   out_item.item_type, out_item.data_byte, out_item.command_code,
                   out_item.data_count, out_item.status, out_item.last);
        mismatch_count++;
      end else begin
        want = pending_parse_results.pop_front();
        bad = (out_item.item_type !== want.item_type)
           || (out_item.data_byte !== want.data_byte)
           || (out_item.command_code !== want.command_code)
           || (out_item.data_count !== want.data_count)
           || (out_item.status !== want.status)
           || (out_item.last !== want.last);
        if (bad) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch at %0t: expected ", $time,
                     "type %0d data %02h cmd %02h count %0d status %0d last %0d",
                     want.item_type, want.data_byte, want.command_code,
                     want.data_count, want.status, want.last);
            $display("                  got ",
                     "type %0d data %02h cmd %02h count %0d status %0d last %0d",
                     out_item.item_type, out_item.data_byte, out_item.command_code,
                     out_item.data_count, out_item.status, out_item.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without any transfer means the block is hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]   phase_marker [PHASE_COUNT];
    logic [15:0]  phase_max [PHASE_COUNT];
    int unsigned  phase_start;
    phase_marker = '{8'hA5, 8'hFF, 8'h00, 8'h5A, 8'h3C, 8'h7E};
    phase_max    = '{16'd0, 16'hFFFF, 16'd5, 16'd12, 16'd0, 16'd8};

    // directed bytes under the reset register values (marker 00, no size limit)
    directed_rows = '{
      // wrong marker, then the rest of the buffer is swallowed
      '{'{8'h05, 1'b0}, 1'b1, verdict_item(scfp_pkg::ST_BAD_MARKER, 8'h00, 16'd0)},
      '{'{8'hAA, 1'b1}, 1'b0, '0},
      // buffer ends on the marker itself
      '{'{8'h00, 1'b1}, 1'b1, verdict_item(scfp_pkg::ST_TRUNCATED, 8'h00, 16'd0)},
      // wrong marker with the end flag still reports bad marker
      '{'{8'hFF, 1'b1}, 1'b1, verdict_item(scfp_pkg::ST_BAD_MARKER, 8'h00, 16'd0)},
      // empty frame with a good check byte
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1}, 1'b1, verdict_item(scfp_pkg::ST_OK, 8'h00, 16'd0)},
      // empty frame with a bad check byte, reported as the command
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h5A, 1'b1}, 1'b1, verdict_item(scfp_pkg::ST_BAD_SUM, 8'h5A, 16'd0)},
      // three-byte body, good sum
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h03, 1'b0}, 1'b0, '0},
      '{'{8'h81, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFE, 1'b1}, 1'b0, '0},
      // largest length, cut short after one data byte: data item then verdict
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hC3, 1'b0}, 1'b0, '0},
      '{'{8'h3C, 1'b1}, 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want);
    in_valid <= 1'b0;

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      // registers change only once the block has drained; a byte left over from
      // the previous phase may still sit mid-frame in the parser
      while (pending_parse_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      reg_write(scfp_pkg::REG_MARKER,
                (p == 4) ? 32'($urandom_range(0, 255)) : 32'(phase_marker[p]));
      reg_write(scfp_pkg::REG_MAX_DATA,
                (p == 4) ? 32'($urandom_range(0, 20)) : 32'(phase_max[p]));

      // sender idles lightly first while the receiver stalls a lot, then the
      // reverse, then full rate both ways
      tx_idle_pct = (p < 2) ? 12 : (p < 4) ? 74 : 0;
      rx_idle_pct = (p < 2) ? 74 : (p < 4) ? 12 : 0;
      // long receiver hold-off at full input rate: the block fills and stops taking bytes
      if (p == 4) long_stall_request = 1'b1;

      phase_start = parsed_bytes;
      while ((parsed_bytes - phase_start < BYTES_PER_PHASE)
             || (p == PHASE_COUNT - 1 && rx_stream.size() != 0)) begin
        if (rx_stream.size() == 0) queue_sequence();
        send_byte(rx_stream.pop_front(), 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    while (pending_parse_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_parse_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
